[rtl/core/rds_pkg.sv]
`default_nettype none
package rds_pkg;

	// sine table geometry, depth is a power of two
	localparam int TABLE_DEPTH = 128;
	localparam int ADDR_W      = $clog2(TABLE_DEPTH);
	localparam int IDX_W       = 7;

	// slice count range and start entry slots
	localparam int MIN_SLICES = 3;
	localparam int MAX_SLICES = 11;
	localparam int NUM_SLOTS  = MAX_SLICES - MIN_SLICES + 1;
	localparam int SLOT_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

	// vertex components: position x, y, z then texture s, t
	localparam int          NUM_COMP   = 5;
	localparam logic [2:0]  COMP_LAST  = 3'(NUM_COMP);
	localparam logic [2:0]  COMP_TEX_S = 3'd3;

	localparam logic [1:0] OP_LOAD_ENTRY = 2'd0;
	localparam logic [1:0] OP_LOAD_START = 2'd1;
	localparam logic [1:0] OP_EXPAND     = 2'd2;

	typedef logic [ADDR_W-1:0] addr_t;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
	} entry_t;

	// tag that travels with a product through the multiply stage
	typedef struct packed {
		logic       vld;
		logic [2:0] comp;
	} mac_tag_t;

	function automatic addr_t wrap_index(input logic [IDX_W-1:0] idx);
		localparam int IW = (ADDR_W > IDX_W) ? ADDR_W : IDX_W;
		logic [IW-1:0] t;
		t = IW'(idx);
		return t[ADDR_W-1:0];
	endfunction

	function automatic logic [3:0] clamp_slices(input logic [3:0] n);
		logic [3:0] r;
		r = n;
		if (n < 4'(MIN_SLICES))
			r = 4'(MIN_SLICES);
		if (n > 4'(MAX_SLICES))
			r = 4'(MAX_SLICES);
		return r;
	endfunction

endpackage
`default_nettype wire

[rtl/core/rds_table_ram.sv]
`default_nettype none
module rds_table_ram (
	input  wire logic           clk,
	input  wire logic           we,
	input  wire rds_pkg::addr_t waddr,
	input  wire rds_pkg::entry_t wdata,
	input  wire rds_pkg::addr_t raddr,
	output rds_pkg::entry_t     rdata
);
	import rds_pkg::*;

	entry_t mem_q [TABLE_DEPTH];
	entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

[rtl/core/rds_mac.sv]
`default_nettype none
module rds_mac (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire rds_pkg::mac_tag_t  issue,
	input  wire logic signed [31:0] op_a,
	input  wire logic signed [31:0] op_b,
	input  wire logic signed [31:0] base,
	output rds_pkg::mac_tag_t       tag_s1,
	output logic signed [31:0]      result
);
	import rds_pkg::*;

	mac_tag_t           tag_q_s1;
	logic signed [63:0] prod_s1;
	logic signed [48:0] sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_q_s1 <= '0;
		end else begin
			tag_q_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (issue.vld)
			prod_s1 <= op_a * op_b;
	end

	// floor of product / 65536 is the arithmetic shift, then one saturation
	assign sum = {{17{base[31]}}, base} + {prod_s1[63], prod_s1[63:16]};

	always_comb begin
		if (sum[48:31] == '0 || sum[48:31] == '1)
			result = sum[31:0];
		else if (sum[48])
			result = 32'sh8000_0000;
		else
			result = 32'sh7fff_ffff;
	end

	assign tag_s1 = tag_q_s1;

endmodule
`default_nettype wire

[rtl/core/radial_distort_strip_builder.sv]
// sequence: a load finishes in its accept cycle; a sprite of n slices runs, per slice, table reads,
//   then 4 ring vertices each computed and then shown, then 1 centre vertex
// throughput: one item at a time; the single 32x32 multiplier runs 5 products per ring vertex
//   and the one table read port fetches 4 entries per slice
// reset: arst_n clears the sequencer; table and start entries hold garbage until loaded
`default_nettype none
module radial_distort_strip_builder (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [1:0]         operation,
	input  wire logic [6:0]         table_index,
	input  wire logic signed [31:0] vec_x,
	input  wire logic signed [31:0] vec_y,
	input  wire logic signed [31:0] vec_z,
	input  wire logic signed [31:0] tex_s,
	input  wire logic signed [31:0] tex_t,
	input  wire logic signed [31:0] scale_outer,
	input  wire logic signed [31:0] scale_inner,
	input  wire logic signed [31:0] scale_tex,
	input  wire logic [3:0]         slices,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [31:0]      pos_out_x,
	output logic signed [31:0]      pos_out_y,
	output logic signed [31:0]      pos_out_z,
	output logic signed [31:0]      tex_out_s,
	output logic signed [31:0]      tex_out_t,
	output logic                    end_of_strip
);
	import rds_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_FETCH,
		S_MAC,
		S_OUT
	} state_t;

	state_t state_q;

	// sequencer counters
	logic [3:0] slice_q;
	logic [2:0] cnt_q;   // table read issue, entries A..D
	logic [2:0] vtx_q;   // vertex within slice: outer A, outer C, inner A, inner C, centre
	logic [2:0] comp_q;  // component being issued to the multiplier

	// sprite payload, held for the whole expansion
	logic signed [31:0] cx_q, cy_q, cz_q, cs_q, ct_q;
	logic signed [31:0] so_q, si_q, st_q;
	logic [3:0]         n_q;
	addr_t              base_q;

	logic [IDX_W-1:0] start_q [NUM_SLOTS];
	entry_t           ent_q [4];

	// vertex being built and then shown on the output
	logic signed [31:0] vert_q [NUM_COMP];
	logic               eos_q;

	logic        in_acc, out_acc;
	logic [3:0]  n_in;
	logic [SLOT_W-1:0] slot_in;
	addr_t       raddr;
	entry_t      rdata;
	entry_t      wdata;
	logic [1:0]  ent_wr_idx;
	logic        tex_comp;
	entry_t      op_ent;
	logic signed [31:0] op_a, op_b, mac_base, mac_res;
	mac_tag_t    issue, tag_s1;
	logic        last_slice;

	assign in_acc  = in_valid && !in_stall;
	assign out_acc = out_valid && !out_stall;

	// busy for the whole expansion, loads finish in their accept cycle
	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = (state_q == S_OUT);

	assign n_in       = clamp_slices(slices);
	assign slot_in    = SLOT_W'(n_in - 4'(MIN_SLICES));
	assign last_slice = (slice_q == n_q - 4'd1);

	// entries A..D of slice i sit at base + 2i + 0..3, wrapping around the table
	assign raddr = base_q + addr_t'({slice_q, 1'b0}) + addr_t'(cnt_q[1:0]);
	assign ent_wr_idx = 2'(cnt_q - 3'd1);

	assign wdata = '{x: vec_x, y: vec_y, z: vec_z};

	rds_table_ram u_ram (
		.clk   (clk),
		.we    (in_acc && operation == OP_LOAD_ENTRY),
		.waddr (wrap_index(table_index)),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	// operand selection for the shared multiplier
	// position comes from A or C, texture offset from B or D
	assign tex_comp = (comp_q >= COMP_TEX_S);
	assign op_ent   = ent_q[{vtx_q[0], tex_comp}];

	always_comb begin
		case (comp_q) inside
			3'd0, 3'd3: op_a = op_ent.x;
			3'd1, 3'd4: op_a = op_ent.y;
			default:    op_a = op_ent.z;
		endcase
		// outer ring uses one scale, inner ring splits position and texture
		if (!vtx_q[1])
			op_b = so_q;
		else if (tex_comp)
			op_b = st_q;
		else
			op_b = si_q;
	end

	assign issue.vld  = (state_q == S_MAC) && (comp_q < COMP_LAST);
	assign issue.comp = comp_q;

	always_comb begin
		case (tag_s1.comp)
			3'd0:    mac_base = cx_q;
			3'd1:    mac_base = cy_q;
			3'd2:    mac_base = cz_q;
			3'd3:    mac_base = cs_q;
			default: mac_base = ct_q;
		endcase
	end

	rds_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.issue  (issue),
		.op_a   (op_a),
		.op_b   (op_b),
		.base   (mac_base),
		.tag_s1 (tag_s1),
		.result (mac_res)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			slice_q <= '0;
			cnt_q   <= '0;
			vtx_q   <= '0;
			comp_q  <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_acc && operation == OP_EXPAND) begin
						state_q <= S_FETCH;
						slice_q <= '0;
						cnt_q   <= '0;
					end
				end
				S_FETCH: begin
					cnt_q <= cnt_q + 3'd1;
					if (cnt_q == 3'd4) begin
						state_q <= S_MAC;
						vtx_q   <= '0;
						comp_q  <= '0;
					end
				end
				S_MAC: begin
					if (comp_q < COMP_LAST)
						comp_q <= comp_q + 3'd1;
					else
						state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_acc) begin
						if (vtx_q < 3'd3) begin
							vtx_q   <= vtx_q + 3'd1;
							comp_q  <= '0;
							state_q <= S_MAC;
						end else if (vtx_q == 3'd3) begin
							vtx_q <= 3'd4;
						end else if (last_slice) begin
							state_q <= S_IDLE;
						end else begin
							slice_q <= slice_q + 4'd1;
							cnt_q   <= '0;
							state_q <= S_FETCH;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_acc && operation == OP_LOAD_START)
			start_q[slot_in] <= table_index;
		if (in_acc && operation == OP_EXPAND) begin
			cx_q   <= vec_x;
			cy_q   <= vec_y;
			cz_q   <= vec_z;
			cs_q   <= tex_s;
			ct_q   <= tex_t;
			so_q   <= scale_outer;
			si_q   <= scale_inner;
			st_q   <= scale_tex;
			n_q    <= n_in;
			base_q <= wrap_index(start_q[slot_in]);
		end
		// registered read data lands in the cycle after its address
		if (state_q == S_FETCH && cnt_q != 3'd0)
			ent_q[ent_wr_idx] <= rdata;
		if (tag_s1.vld) begin
			vert_q[tag_s1.comp] <= mac_res;
			eos_q               <= 1'b0;
		end
		// centre vertex follows inner C
		if (out_acc && vtx_q == 3'd3) begin
			vert_q[0] <= cx_q;
			vert_q[1] <= cy_q;
			vert_q[2] <= cz_q;
			vert_q[3] <= cs_q;
			vert_q[4] <= ct_q;
			eos_q     <= last_slice;
		end
	end

	assign pos_out_x    = vert_q[0];
	assign pos_out_y    = vert_q[1];
	assign pos_out_z    = vert_q[2];
	assign tex_out_s    = vert_q[3];
	assign tex_out_t    = vert_q[4];
	assign end_of_strip = eos_q;

	// input side is open only while nothing is being shown
	a_idle_no_out: assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall |-> !out_valid)
		else $error("input open while a vertex beat is pending");

	// last centre beat returns the block to idle
	a_eos_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && end_of_strip |=> !out_valid && !in_stall)
		else $error("block still busy after end of strip");

	// no product may land while a vertex is on the output
	a_no_write_out: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_OUT |-> !tag_s1.vld)
		else $error("multiplier write during output beat");

	// centre vertex never carries a pending multiplier issue
	a_centre_no_issue: assert property (@(posedge clk) disable iff (!arst_n)
		vtx_q == 3'd4 |-> !issue.vld)
		else $error("multiplier issued for centre vertex");

endmodule
`default_nettype wire
